@@ rtl/ecmk_pkg.sv @@
// Shared types and constants for the element centroid Morton key block.
`timescale 1ns / 1ps
`default_nettype none

package ecmk_pkg;

  // Fixed field widths of the item, result and register formats.
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned LEN_W      = 31;
  localparam int unsigned VCNT_W     = 4;
  localparam int unsigned KEY_W      = 60;
  localparam int unsigned INDEX_W    = 32;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;

  // Register reset values.
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST   = LEN_W'(65536);
  localparam logic [VCNT_W-1:0] VERTEX_COUNT_RST = VCNT_W'(8);

  // Register word indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_ORIGIN_Z     = 3'd2,
    REG_MAX_LENGTH   = 3'd3,
    REG_VERTEX_COUNT = 3'd4
  } reg_idx_e;

  // One input item: a mesh vertex in signed Q16.16.
  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
  } in_item_t;

  // One result item: the key of a finished element.
  typedef struct packed {
    logic [KEY_W-1:0]   morton_key;
    logic [INDEX_W-1:0] element_index;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic [LEN_W-1:0]          max_length;
    logic [VCNT_W-1:0]         vertex_count;
  } cfg_t;

  // Main sequencer states.
  typedef enum logic [2:0] {
    ST_ACC,
    ST_LEN,
    ST_DIFF,
    ST_DIV,
    ST_EMIT
  } seq_state_e;

  // Divider states.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_STEP
  } div_state_e;

  // Axis being quantized.
  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

endpackage

`default_nettype wire

@@ rtl/ecmk_cfg.sv @@
// APB register file holding the origin, length and vertex count settings.
`timescale 1ns / 1ps
`default_nettype none

module ecmk_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ecmk_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [ecmk_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [ecmk_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output ecmk_pkg::cfg_t                        cfg_o
);
  import ecmk_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_ORIGIN_X:     cfg_d.origin_x     = pwdata[COORD_W-1:0];
        REG_ORIGIN_Y:     cfg_d.origin_y     = pwdata[COORD_W-1:0];
        REG_ORIGIN_Z:     cfg_d.origin_z     = pwdata[COORD_W-1:0];
        REG_MAX_LENGTH:   cfg_d.max_length   = pwdata[LEN_W-1:0];
        REG_VERTEX_COUNT: cfg_d.vertex_count = pwdata[VCNT_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  // Read back; unused addresses read as zero.
  always_comb begin
    case (idx)
      REG_ORIGIN_X:     prdata = cfg_q.origin_x;
      REG_ORIGIN_Y:     prdata = cfg_q.origin_y;
      REG_ORIGIN_Z:     prdata = cfg_q.origin_z;
      REG_MAX_LENGTH:   prdata = APB_DATA_W'(cfg_q.max_length);
      REG_VERTEX_COUNT: prdata = APB_DATA_W'(cfg_q.vertex_count);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x     <= '0;
      cfg_q.origin_y     <= '0;
      cfg_q.origin_z     <= '0;
      cfg_q.max_length   <= MAX_LENGTH_RST;
      cfg_q.vertex_count <= VERTEX_COUNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ecmk_div.sv @@
// Shared restoring divider that quantizes one axis, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ecmk_div #(
  parameter int unsigned BITS_PER_AXIS = 20,
  parameter int unsigned DIV_W         = 35
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic signed [DIV_W+1:0]          dividend_i,
  input  wire logic        [DIV_W-1:0]          divisor_i,
  output logic                                  done_o,
  output logic             [BITS_PER_AXIS-1:0]  quot_o
);
  import ecmk_pkg::*;

  localparam int unsigned DiffW = DIV_W + 2;
  localparam int unsigned RemW  = DIV_W + 1;
  localparam int unsigned StepW = (BITS_PER_AXIS > 1) ? $clog2(BITS_PER_AXIS) : 1;

  div_state_e                state_q, state_d;
  logic [StepW-1:0]          step_q, step_d;
  logic                      done_q, done_d;
  logic signed [DiffW-1:0]   dvd_q, dvd_d;
  logic [DIV_W-1:0]          dvs_q, dvs_d;
  logic [RemW-1:0]           rem_q, rem_d;
  logic [BITS_PER_AXIS-1:0]  quot_q, quot_d;
  logic [RemW:0]             trial;
  logic [RemW-1:0]           dvd_mag;

  assign dvd_mag = dvd_q[DiffW-2:0];
  assign trial   = {1'b0, rem_q} - {2'b00, dvs_q};
  assign done_o  = done_q;
  assign quot_o  = quot_q;

  // Negative differences give zero, quotients of 2^B or more saturate,
  // everything else runs one compare-subtract step per quotient bit.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          dvd_d   = dividend_i;
          dvs_d   = divisor_i;
          state_d = DIV_CHECK;
        end
      end
      DIV_CHECK: begin
        if (dvd_q[DiffW-1]) begin
          quot_d  = '0;
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end else if (dvd_mag >= {dvs_q, 1'b0}) begin
          quot_d  = '1;
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end else begin
          rem_d   = dvd_mag;
          quot_d  = '0;
          step_d  = StepW'(BITS_PER_AXIS - 1);
          state_d = DIV_STEP;
        end
      end
      DIV_STEP: begin
        quot_d = {quot_q[BITS_PER_AXIS-2:0], ~trial[RemW]};
        if (trial[RemW]) begin
          rem_d = {rem_q[RemW-2:0], 1'b0};
        end else begin
          rem_d = {trial[RemW-2:0], 1'b0};
        end
        if (step_q == '0) begin
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end else begin
          step_d = step_q - StepW'(1);
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  // Operand and partial results.
  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

endmodule

`default_nettype wire

@@ rtl/element_centroid_morton_key_top.sv @@
// Top level: vertex accumulation, axis sequencer, key interleave and output register.
`timescale 1ns / 1ps
`default_nettype none

// Vertices arrive one item at a time and are summed until the element's vertex
// count is reached; a vertex that does not close an element is accepted with
// the input left ready. The closing vertex starts the quantization: the ST_LEN
// state forms the divisor (vertex count times max_length), then each of the
// three axes passes through the single shared divider, which takes a setup
// step, a range check and one compare-subtract step per key bit. The input is
// not ready during that time. The key is held in an output register, so the
// next element's vertices are accepted while a finished key waits to be taken.
module element_centroid_morton_key_top #(
  parameter int unsigned MAX_VERTICES  = 8,
  parameter int unsigned BITS_PER_AXIS = 20
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire ecmk_pkg::in_item_t               in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output ecmk_pkg::out_item_t                   out_item_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ecmk_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [ecmk_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [ecmk_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import ecmk_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SumW  = COORD_W + $clog2(MAX_VERTICES);
  localparam int unsigned DivW  = LEN_W + CntW;
  localparam int unsigned DiffW = DivW + 2;
  localparam int unsigned FullW = 3 * BITS_PER_AXIS;

  cfg_t cfg;

  // Configuration registers.
  ecmk_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  seq_state_e               state_q, state_d;
  axis_e                    axis_q;
  logic signed [SumW-1:0]   sum_x_q, sum_y_q, sum_z_q;
  logic [CntW-1:0]          seen_q;
  logic [CntW-1:0]          n_q;
  logic [INDEX_W-1:0]       elem_cnt_q;
  logic [DivW-1:0]          divisor_q;
  logic [BITS_PER_AXIS-1:0] qx_q, qy_q, qz_q;
  logic                     out_valid_q;
  out_item_t                out_item_q;

  logic                     in_fire;
  logic [CntW-1:0]          n_w;
  logic [VCNT_W-1:0]        need;
  logic                     close_w;
  logic [LEN_W-1:0]         len_w;
  logic signed [SumW-1:0]   sum_sel;
  logic signed [COORD_W-1:0] org_sel;
  logic signed [DiffW-1:0]  diff_w;
  logic                     div_start;
  logic                     div_done;
  logic [BITS_PER_AXIS-1:0] div_quot;
  logic                     emit_load;
  logic [FullW-1:0]         key_full;

  assign in_fire = in_valid_i && in_ready_o;
  assign n_w     = seen_q + CntW'(1);

  // Vertex count after clamping into one to MAX_VERTICES.
  always_comb begin
    if (cfg.vertex_count == '0) begin
      need = VCNT_W'(1);
    end else if (cfg.vertex_count > VCNT_W'(MAX_VERTICES)) begin
      need = VCNT_W'(MAX_VERTICES);
    end else begin
      need = cfg.vertex_count;
    end
  end

  assign close_w = (VCNT_W'(n_w) >= need);
  assign len_w   = (cfg.max_length == '0) ? LEN_W'(1) : cfg.max_length;

  // Operands of the axis under quantization.
  always_comb begin
    case (axis_q)
      AXIS_X:  begin sum_sel = sum_x_q; org_sel = cfg.origin_x; end
      AXIS_Y:  begin sum_sel = sum_y_q; org_sel = cfg.origin_y; end
      AXIS_Z:  begin sum_sel = sum_z_q; org_sel = cfg.origin_z; end
      default: begin sum_sel = sum_x_q; org_sel = cfg.origin_x; end
    endcase
  end

  assign diff_w = DiffW'(sum_sel)
                - (DiffW'(signed'({1'b0, n_q})) * DiffW'(org_sel));

  // Shared divider.
  ecmk_div #(
    .BITS_PER_AXIS (BITS_PER_AXIS),
    .DIV_W         (DivW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff_w),
    .divisor_i  (divisor_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACC:  if (in_fire && close_w) state_d = ST_LEN;
      ST_LEN:  state_d = ST_DIFF;
      ST_DIFF: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = (axis_q == AXIS_Z) ? ST_EMIT : ST_DIFF;
        end
      end
      ST_EMIT: if (!out_valid_q || out_ready_i) state_d = ST_ACC;
      default: state_d = ST_ACC;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    emit_load  = 1'b0;
    case (state_q)
      ST_ACC:  in_ready_o = 1'b1;
      ST_DIFF: div_start  = 1'b1;
      ST_EMIT: emit_load  = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  // Bit interleave of the three quantized axes.
  for (genvar b = 0; b < BITS_PER_AXIS; b++) begin : g_spread
    assign key_full[3*b]     = qx_q[b];
    assign key_full[3*b + 1] = qy_q[b];
    assign key_full[3*b + 2] = qz_q[b];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      axis_q      <= AXIS_X;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_z_q     <= '0;
      seen_q      <= '0;
      elem_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        sum_x_q <= sum_x_q + SumW'(in_item_i.vertex_x);
        sum_y_q <= sum_y_q + SumW'(in_item_i.vertex_y);
        sum_z_q <= sum_z_q + SumW'(in_item_i.vertex_z);
        seen_q  <= close_w ? '0 : n_w;
      end
      if (state_q == ST_LEN) begin
        axis_q <= AXIS_X;
      end else if (state_q == ST_DIV && div_done) begin
        case (axis_q)
          AXIS_X:  axis_q <= AXIS_Y;
          AXIS_Y:  axis_q <= AXIS_Z;
          default: axis_q <= AXIS_X;
        endcase
      end
      if (emit_load) begin
        sum_x_q    <= '0;
        sum_y_q    <= '0;
        sum_z_q    <= '0;
        elem_cnt_q <= elem_cnt_q + INDEX_W'(1);
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire && close_w) begin
      n_q <= n_w;
    end
    if (state_q == ST_LEN) begin
      divisor_q <= DivW'(n_q) * DivW'(len_w);
    end
    if (state_q == ST_DIV && div_done) begin
      case (axis_q)
        AXIS_X:  qx_q <= div_quot;
        AXIS_Y:  qy_q <= div_quot;
        default: qz_q <= div_quot;
      endcase
    end
    if (emit_load) begin
      out_item_q.morton_key    <= KEY_W'(key_full);
      out_item_q.element_index <= elem_cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

@@ rtl/ecmk_checker.sv @@
// Port-level checker for the element centroid Morton key block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module ecmk_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire ecmk_pkg::out_item_t out_item_o
);
  import ecmk_pkg::*;

  logic [INDEX_W-1:0] exp_idx_q;

  // Next element index expected on the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      exp_idx_q <= exp_idx_q + INDEX_W'(1);
    end
  end

  // Elements are numbered in order, none skipped or repeated.
  a_index_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.element_index == exp_idx_q)
    else $error("element index out of sequence");

  // The input only closes right after a vertex that ended an element.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o))
    else $error("input ready dropped without an accepted item");

  // A waiting result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // A waiting result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_item_o))
    else $error("result payload changed while stalled");

endmodule

bind element_centroid_morton_key_top ecmk_checker u_ecmk_checker (.*);

`default_nettype wire
